>>> rtl/core/ambz_pkg.sv
`default_nettype none

package ambz_pkg;

    localparam int CHANNELS   = 4;
    localparam int COEF_W     = 16;
    localparam int COEF_FRAC  = 14;
    localparam int ZOOM_W     = 16;
    localparam int BLEND_W    = 17;
    localparam int GAIN_W     = 16;
    localparam int RECIP_W    = 18;
    localparam int Q15_FRAC   = 15;
    localparam int RECIP_FRAC = 16;
    // growth of the front mic over a sample after the coefficient shift
    localparam int MIC_GROW   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int STAGES     = 6;

    localparam logic signed [ZOOM_W-1:0]  ZOOM_MAX  = 16'sd32440;
    localparam logic signed [ZOOM_W+1:0]  ZOOM_ONE  = 18'sd32768;
    localparam logic [GAIN_W-1:0]         REAR_RST  = 16'd32768;
    localparam logic [RECIP_W-1:0]        RECIP_RST = 18'd65536;

    typedef logic [STAGES-1:0] t_stage_en;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZOOM           = 3'd0,
        CFG_REAR_GAIN      = 3'd1,
        CFG_NORM_RECIP     = 3'd2,
        CFG_FRONT_COEFS    = 3'd3,
        CFG_WEIGHTED_COEFS = 3'd4
    } t_cfg_idx;

endpackage

`default_nettype wire

>>> rtl/core/ambz_in_if.sv
`default_nettype none

interface ambz_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_ch0;
    logic signed [SAMPLE_BITS-1:0] in_ch1;
    logic signed [SAMPLE_BITS-1:0] in_ch2;
    logic signed [SAMPLE_BITS-1:0] in_ch3;
    logic                          end_of_block;

    modport source (
        output valid, in_ch0, in_ch1, in_ch2, in_ch3, end_of_block,
        input  ready
    );
    modport sink (
        input  valid, in_ch0, in_ch1, in_ch2, in_ch3, end_of_block,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/ambz_out_if.sv
`default_nettype none

interface ambz_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_ch0;
    logic signed [SAMPLE_BITS-1:0] out_ch1;
    logic signed [SAMPLE_BITS-1:0] out_ch2;
    logic signed [SAMPLE_BITS-1:0] out_ch3;
    logic                          block_last;

    modport source (
        output valid, out_ch0, out_ch1, out_ch2, out_ch3, block_last,
        input  ready
    );
    modport sink (
        input  valid, out_ch0, out_ch1, out_ch2, out_ch3, block_last,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/ambz_lane.sv
`default_nettype none

module ambz_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                            i_clk,
    input  wire ambz_pkg::t_stage_en                             i_en,
    input  wire logic signed [SAMPLE_BITS-1:0]                   i_x,
    input  wire logic signed [ambz_pkg::COEF_W-1:0]              i_wcoef,
    input  wire logic signed [ambz_pkg::COEF_W-1:0]              i_fcoef,
    input  wire logic signed [ambz_pkg::ZOOM_W-1:0]              i_zoom,
    input  wire logic [ambz_pkg::BLEND_W-1:0]                    i_blend,
    input  wire logic [ambz_pkg::GAIN_W-1:0]                     i_rear_gain,
    input  wire logic [ambz_pkg::RECIP_W-1:0]                    i_norm_recip,
    output      logic signed [SAMPLE_BITS+ambz_pkg::COEF_W-1:0]  o_prod,
    input  wire logic signed [SAMPLE_BITS+ambz_pkg::MIC_GROW-1:0] i_mic,
    output      logic signed [SAMPLE_BITS-1:0]                   o_y
);
    import ambz_pkg::*;

    localparam int S         = SAMPLE_BITS;
    localparam int P_W       = S + COEF_W;
    localparam int CZ_FULL_W = 2 * COEF_W;
    localparam int CZ_W      = CZ_FULL_W - COEF_FRAC;
    localparam int BX_W      = S + BLEND_W + 1;
    localparam int RP_W      = S + GAIN_W + 1;
    localparam int RS_W      = RP_W - Q15_FRAC;
    localparam int MIC_W     = S + MIC_GROW;
    localparam int T_W       = CZ_W + MIC_W;
    localparam int ACC_W     = T_W + 2;
    localparam int V_W       = ACC_W - Q15_FRAC;
    localparam int YP_W      = V_W + RECIP_W + 1;
    localparam int SH_W      = YP_W - RECIP_FRAC;

    localparam logic signed [CZ_FULL_W-1:0] CZ_HALF  = CZ_FULL_W'(1 << (COEF_FRAC - 1));
    localparam logic signed [RP_W-1:0]      RP_HALF  = RP_W'(1 << (Q15_FRAC - 1));
    localparam logic signed [ACC_W-1:0]     ACC_HALF = ACC_W'(1 << (Q15_FRAC - 1));
    localparam logic signed [YP_W-1:0]      YP_HALF  = YP_W'(1 << (RECIP_FRAC - 1));
    localparam logic signed [S-1:0]         SAT_MAX  = {1'b0, {(S-1){1'b1}}};
    localparam logic signed [S-1:0]         SAT_MIN  = {1'b1, {(S-1){1'b0}}};

    function automatic logic signed [S-1:0] sat_s(input logic signed [SH_W-1:0] v);
        logic [SH_W-S:0] hi;
        hi = v[SH_W-1:S-1];
        if (hi == '0 || hi == '1) begin
            return v[S-1:0];
        end else if (v[SH_W-1]) begin
            return SAT_MIN;
        end else begin
            return SAT_MAX;
        end
    endfunction

    // stage 1: products against the configuration
    logic signed [P_W-1:0]       w_prod;
    logic signed [CZ_FULL_W-1:0] w_cz_full;
    logic signed [CZ_FULL_W-1:0] w_cz_rnd;
    logic signed [BX_W-1:0]      w_bx;
    logic signed [RP_W-1:0]      w_rp;

    logic signed [P_W-1:0]  r1_prod;
    logic signed [CZ_W-1:0] r1_cz;
    logic signed [BX_W-1:0] r1_bx;
    logic signed [RP_W-1:0] r1_rp;
    logic                   r1_front;

    assign w_prod    = i_wcoef * i_x;
    assign w_cz_full = i_fcoef * i_zoom;
    assign w_cz_rnd  = w_cz_full + CZ_HALF;
    assign w_bx      = $signed({1'b0, i_blend}) * i_x;
    assign w_rp      = $signed({1'b0, i_rear_gain}) * i_x;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_prod  <= w_prod;
            r1_cz    <= w_cz_rnd[CZ_FULL_W-1:COEF_FRAC];
            r1_bx    <= w_bx;
            r1_rp    <= w_rp;
            r1_front <= (i_fcoef != '0);
        end
    end

    assign o_prod = r1_prod;

    // stage 2: rear channel result finished here, mic formed in the merge
    logic signed [RP_W-1:0] w_rp_rnd;
    logic signed [RS_W-1:0] w_rear_sh;

    logic signed [CZ_W-1:0] r2_cz;
    logic signed [BX_W-1:0] r2_bx;
    logic signed [S-1:0]    r2_rear;
    logic                   r2_front;

    assign w_rp_rnd  = r1_rp + RP_HALF;
    assign w_rear_sh = w_rp_rnd[RP_W-1:Q15_FRAC];

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_cz    <= r1_cz;
            r2_bx    <= r1_bx;
            r2_rear  <= sat_s(SH_W'(w_rear_sh));
            r2_front <= r1_front;
        end
    end

    // stage 3: coef*zoom times mic
    logic signed [T_W-1:0]  r3_t;
    logic signed [BX_W-1:0] r3_bx;
    logic signed [S-1:0]    r3_rear;
    logic                   r3_front;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_t     <= r2_cz * i_mic;
            r3_bx    <= r2_bx;
            r3_rear  <= r2_rear;
            r3_front <= r2_front;
        end
    end

    // stage 4: blend sum and first rounding
    logic signed [ACC_W-1:0] w_acc;

    logic signed [V_W-1:0] r4_v;
    logic signed [S-1:0]   r4_rear;
    logic                  r4_front;

    assign w_acc = r3_bx + r3_t + ACC_HALF;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_v     <= w_acc[ACC_W-1:Q15_FRAC];
            r4_rear  <= r3_rear;
            r4_front <= r3_front;
        end
    end

    // stage 5: normalisation
    logic signed [YP_W-1:0] r5_yp;
    logic signed [S-1:0]    r5_rear;
    logic                   r5_front;

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r5_yp    <= r4_v * $signed({1'b0, i_norm_recip});
            r5_rear  <= r4_rear;
            r5_front <= r4_front;
        end
    end

    // stage 6: round, saturate, pick front or rear
    logic signed [YP_W-1:0] w_yp_rnd;

    assign w_yp_rnd = r5_yp + YP_HALF;

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            o_y <= r5_front ? sat_s(w_yp_rnd[YP_W-1:RECIP_FRAC]) : r5_rear;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ambz_mic.sv
`default_nettype none

module ambz_mic #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                             i_clk,
    input  wire logic                                             i_en,
    input  wire logic signed [SAMPLE_BITS+ambz_pkg::COEF_W-1:0]   i_prod [ambz_pkg::CHANNELS],
    output      logic signed [SAMPLE_BITS+ambz_pkg::MIC_GROW-1:0] o_mic
);
    import ambz_pkg::*;

    localparam int P_W   = SAMPLE_BITS + COEF_W;
    localparam int SUM_W = P_W + 3;
    localparam int MIC_W = SAMPLE_BITS + MIC_GROW;

    localparam logic signed [SUM_W-1:0] SUM_HALF = SUM_W'(1 << (COEF_FRAC - 1));

    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] w_rnd;

    always_comb begin
        w_sum = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            w_sum = w_sum + SUM_W'(i_prod[c]);
        end
    end

    assign w_rnd = w_sum + SUM_HALF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mic <= w_rnd[MIC_W+COEF_FRAC-1:COEF_FRAC];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ambisonic_front_zoom.sv
// throughput: one frame per cycle while the output is ready, four channel lanes in a six-stage pipeline
// a stage moves whenever its successor frees up, so bubbles are squeezed out
// reset: synchronous, active low; clears the pipeline and loads the register
// defaults (zoom 0, rear gain 1.0, norm reciprocal 1.0, coefficients 0)
`default_nettype none

module ambisonic_front_zoom #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    ambz_in_if.sink                                 i_in,
    ambz_out_if.source                              o_out,
    input  wire logic                               i_cfg_we,
    input  wire logic [ambz_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ambz_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ambz_pkg::*;

    localparam int P_W   = SAMPLE_BITS + COEF_W;
    localparam int MIC_W = SAMPLE_BITS + MIC_GROW;

    // configuration
    logic signed [ZOOM_W-1:0]    r_zoom, n_zoom;
    logic [BLEND_W-1:0]          r_blend, n_blend;
    logic [GAIN_W-1:0]           r_rear, n_rear;
    logic [RECIP_W-1:0]          r_recip, n_recip;
    logic [CFG_DATA_W-1:0]       r_front, n_front;
    logic [CFG_DATA_W-1:0]       r_weight, n_weight;
    logic signed [ZOOM_W-1:0]    w_zoom_in;
    logic signed [ZOOM_W-1:0]    w_zoom_clamp;
    logic signed [ZOOM_W+1:0]    w_blend;

    assign w_zoom_in    = $signed(i_cfg_data[ZOOM_W-1:0]);
    assign w_zoom_clamp = (w_zoom_in > ZOOM_MAX) ? ZOOM_MAX : w_zoom_in;
    assign w_blend      = ZOOM_ONE - (ZOOM_W+2)'(w_zoom_clamp);

    always_comb begin
        n_zoom   = r_zoom;
        n_blend  = r_blend;
        n_rear   = r_rear;
        n_recip  = r_recip;
        n_front  = r_front;
        n_weight = r_weight;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ZOOM: begin
                    n_zoom  = w_zoom_clamp;
                    n_blend = w_blend[BLEND_W-1:0];
                end
                CFG_REAR_GAIN:      n_rear   = i_cfg_data[GAIN_W-1:0];
                CFG_NORM_RECIP:     n_recip  = i_cfg_data[RECIP_W-1:0];
                CFG_FRONT_COEFS:    n_front  = i_cfg_data;
                CFG_WEIGHTED_COEFS: n_weight = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom   <= '0;
            r_blend  <= ZOOM_ONE[BLEND_W-1:0];
            r_rear   <= REAR_RST;
            r_recip  <= RECIP_RST;
            r_front  <= '0;
            r_weight <= '0;
        end else begin
            r_zoom   <= n_zoom;
            r_blend  <= n_blend;
            r_rear   <= n_rear;
            r_recip  <= n_recip;
            r_front  <= n_front;
            r_weight <= n_weight;
        end
    end

    // pipeline control: a stage loads when it is empty or its successor loads
    t_stage_en         w_en;
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] r_last;

    always_comb begin
        w_en[STAGES-1] = !r_vld[STAGES-1] || o_out.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_last[0] <= i_in.end_of_block;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (w_en[k]) begin
                r_last[k] <= r_last[k-1];
            end
        end
    end

    assign i_in.ready = w_en[0];

    // lanes
    logic signed [SAMPLE_BITS-1:0] w_x [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] w_y [CHANNELS];
    logic signed [P_W-1:0]         w_prod [CHANNELS];
    logic signed [MIC_W-1:0]       w_mic;

    assign w_x[0] = i_in.in_ch0;
    assign w_x[1] = i_in.in_ch1;
    assign w_x[2] = i_in.in_ch2;
    assign w_x[3] = i_in.in_ch3;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        ambz_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .i_clk        (i_clk),
            .i_en         (w_en),
            .i_x          (w_x[g]),
            .i_wcoef      ($signed(r_weight[g*COEF_W +: COEF_W])),
            .i_fcoef      ($signed(r_front[g*COEF_W +: COEF_W])),
            .i_zoom       (r_zoom),
            .i_blend      (r_blend),
            .i_rear_gain  (r_rear),
            .i_norm_recip (r_recip),
            .o_prod       (w_prod[g]),
            .i_mic        (w_mic),
            .o_y          (w_y[g])
        );
    end

    ambz_mic #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mic (
        .i_clk  (i_clk),
        .i_en   (w_en[1]),
        .i_prod (w_prod),
        .o_mic  (w_mic)
    );

    assign o_out.valid      = r_vld[STAGES-1];
    assign o_out.out_ch0    = w_y[0];
    assign o_out.out_ch1    = w_y[1];
    assign o_out.out_ch2    = w_y[2];
    assign o_out.out_ch3    = w_y[3];
    assign o_out.block_last = r_last[STAGES-1];

endmodule

`default_nettype wire
